[rtl/overwrite_ring_buffer_assert.svh]
// Assertion shorthands shared by the ring buffer modules.
// Both expect clk and arst_n in scope.
`ifndef OVERWRITE_RING_BUFFER_ASSERT_SVH
`define OVERWRITE_RING_BUFFER_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define OBR_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define OBR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/obr_pkg.sv]
package obr_pkg;

	localparam int DEF_MAX_DEPTH    = 128;
	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int CNT_W            = 32;
	localparam int CAP_LOG2_W       = 3;
	localparam int POW_W            = (1 << CAP_LOG2_W) + 1;

	localparam logic [CAP_LOG2_W-1:0] CAP_LOG2_RST = 3'd7;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_GET   = 2'd3
	} cmd_t;

	// status captured with each accepted command
	typedef struct packed {
		logic             valid;
		logic             zero;
		logic             full;
		logic             empty;
		logic [CNT_W-1:0] writes;
		logic [CNT_W-1:0] overflows;
	} stat_t;

endpackage

[rtl/obr_if.sv]
interface obr_cmd_if #(
	parameter int SW = obr_pkg::DEF_SAMPLE_WIDTH,
	parameter int IW = $clog2(obr_pkg::DEF_MAX_DEPTH)
);
	logic                 valid;
	logic                 ready;
	obr_pkg::cmd_t        cmd;
	logic signed [SW-1:0] sample_in;
	logic [IW-1:0]        entry_index;

	modport source (output valid, cmd, sample_in, entry_index, input ready);
	modport sink   (input valid, cmd, sample_in, entry_index, output ready);
endinterface

interface obr_res_if #(
	parameter int SW = obr_pkg::DEF_SAMPLE_WIDTH,
	parameter int FW = $clog2(obr_pkg::DEF_MAX_DEPTH + 1)
);
	logic                      valid;
	logic                      ready;
	logic signed [SW-1:0]      sample_out;
	logic [FW-1:0]             fill_level;
	logic                      is_full;
	logic                      is_empty;
	logic [obr_pkg::CNT_W-1:0] writes_total;
	logic [obr_pkg::CNT_W-1:0] overflows_total;

	modport source (output valid, sample_out, fill_level, is_full, is_empty, writes_total,
		overflows_total, input ready);
	modport sink   (input valid, sample_out, fill_level, is_full, is_empty, writes_total,
		overflows_total, output ready);
endinterface

interface obr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [obr_pkg::CAP_LOG2_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[rtl/obr_ram.sv]
module obr_ram #(
	parameter int WIDTH = obr_pkg::DEF_SAMPLE_WIDTH,
	parameter int DEPTH = obr_pkg::DEF_MAX_DEPTH,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/obr_ctrl.sv]
`include "overwrite_ring_buffer_assert.svh"

module obr_ctrl #(
	parameter int MAX_DEPTH    = obr_pkg::DEF_MAX_DEPTH,
	parameter int SAMPLE_WIDTH = obr_pkg::DEF_SAMPLE_WIDTH,
	localparam int AW = $clog2(MAX_DEPTH),
	localparam int FW = $clog2(MAX_DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	obr_cfg_if.sink                 cfg,
	obr_cmd_if.sink                 req,
	input  logic                    s1_adv,
	output obr_pkg::stat_t          stat_s1,
	output logic [FW-1:0]           fill_s1,
	output logic                    ram_we,
	output logic [AW-1:0]           ram_waddr,
	output logic [SAMPLE_WIDTH-1:0] ram_wdata,
	output logic                    ram_re,
	output logic [AW-1:0]           ram_raddr
);

	localparam int PW = obr_pkg::POW_W;
	localparam int CW = obr_pkg::CNT_W;

	function automatic logic [FW-1:0] cap_of(input logic [obr_pkg::CAP_LOG2_W-1:0] l);
		logic [PW-1:0] p;
		p = PW'(1) << l;
		if (32'(p) > MAX_DEPTH) begin
			return FW'(MAX_DEPTH);
		end
		return FW'(p);
	endfunction

	logic [obr_pkg::CAP_LOG2_W-1:0] cap_log2_q;
	logic [AW-1:0] wp_q, rp_q, wp_d, rp_d;
	logic [FW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] wr_q, ov_q, wr_d, ov_d;
	logic          sweep_q;
	logic [FW-1:0] sweep_cnt_q, sweep_lim_q, sweep_nxt;
	logic [FW-1:0] cap, new_cap;
	logic [AW-1:0] mask;
	logic          accept, cfg_take, rd_need, zero;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] gap;

	assign cap      = cap_of(cap_log2_q);
	assign new_cap  = cap_of(cfg.data);
	assign mask     = AW'(cap - FW'(1));
	assign cfg.ready = 1'b1;
	assign cfg_take = cfg.valid;
	assign req.ready = !sweep_q && (!stat_s1.valid || s1_adv);
	assign accept   = req.valid && req.ready;
	assign sweep_nxt = FW'(sweep_cnt_q + FW'(1));
	assign gap      = (wp_q - rp_q) & mask;

	// next pointer and counter values for the command on the input
	always_comb begin
		wp_d    = wp_q;
		rp_d    = rp_q;
		cnt_d   = cnt_q;
		wr_d    = wr_q;
		ov_d    = ov_q;
		zero    = 1'b1;
		rd_need = 1'b0;
		rd_addr = rp_q;
		case (req.cmd)
			obr_pkg::CMD_WRITE: begin
				wp_d = (wp_q + AW'(1)) & mask;
				if (cnt_q >= cap) begin
					rp_d = (rp_q + AW'(1)) & mask;
					ov_d = ov_q + CW'(1);
				end else begin
					cnt_d = cnt_q + FW'(1);
				end
				wr_d = wr_q + CW'(1);
			end
			obr_pkg::CMD_READ: begin
				if (cnt_q != '0) begin
					zero    = 1'b0;
					rd_need = 1'b1;
					rp_d    = (rp_q + AW'(1)) & mask;
					cnt_d   = cnt_q - FW'(1);
				end
			end
			obr_pkg::CMD_PEEK: begin
				rd_addr = (wp_q - AW'(1)) & mask;
				if (cnt_q != '0) begin
					zero    = 1'b0;
					rd_need = 1'b1;
				end
			end
			obr_pkg::CMD_GET: begin
				rd_addr = (rp_q + req.entry_index) & mask;
				zero    = 1'b0;
				rd_need = 1'b1;
			end
			default: ;
		endcase
	end

	// clearing sweep owns the write port; no commands are taken meanwhile
	assign ram_we    = sweep_q || (accept && req.cmd == obr_pkg::CMD_WRITE);
	assign ram_waddr = sweep_q ? sweep_cnt_q[AW-1:0] : wp_q;
	assign ram_wdata = sweep_q ? '0 : req.sample_in;
	assign ram_re    = accept && rd_need;
	assign ram_raddr = rd_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_log2_q    <= obr_pkg::CAP_LOG2_RST;
			wp_q          <= '0;
			rp_q          <= '0;
			cnt_q         <= '0;
			wr_q          <= '0;
			ov_q          <= '0;
			sweep_q       <= 1'b1;
			sweep_cnt_q   <= '0;
			sweep_lim_q   <= FW'(MAX_DEPTH);
			stat_s1       <= '0;
			fill_s1       <= '0;
		end else begin
			if (cfg_take) begin
				cap_log2_q  <= cfg.data;
				wp_q        <= '0;
				rp_q        <= '0;
				cnt_q       <= '0;
				wr_q        <= '0;
				ov_q        <= '0;
				sweep_q     <= 1'b1;
				sweep_cnt_q <= '0;
				// a sweep already running keeps its wider span
				sweep_lim_q <= (sweep_q && sweep_lim_q > new_cap) ? sweep_lim_q : new_cap;
			end else begin
				if (sweep_q) begin
					sweep_cnt_q <= sweep_nxt;
					if (sweep_nxt == sweep_lim_q) begin
						sweep_q <= 1'b0;
					end
				end
				if (accept) begin
					wp_q  <= wp_d;
					rp_q  <= rp_d;
					cnt_q <= cnt_d;
					wr_q  <= wr_d;
					ov_q  <= ov_d;
				end
			end
			if (accept) begin
				stat_s1.valid     <= 1'b1;
				stat_s1.zero      <= zero;
				stat_s1.full      <= (cnt_d == cap);
				stat_s1.empty     <= (cnt_d == '0);
				stat_s1.writes    <= wr_d;
				stat_s1.overflows <= ov_d;
				fill_s1           <= cnt_d;
			end else if (s1_adv) begin
				stat_s1.valid <= 1'b0;
			end
		end
	end

	`OBR_ASSERT_ALWAYS(a_cnt_le_cap, cnt_q <= cap, "fill count above capacity")
	`OBR_ASSERT_ALWAYS(a_ptr_gap, gap == (cnt_q[AW-1:0] & mask), "pointer gap vs fill count")
	`OBR_ASSERT_ALWAYS(a_no_rw_clash, !(ram_we && ram_re), "read and write in one cycle")

endmodule

[rtl/overwrite_ring_buffer.sv]
// Overwrite-oldest ring buffer of signed samples.
// Channels: req carries one command per transfer (write, read oldest, peek newest,
// get by offset from the oldest); rsp returns exactly one result per command, in
// order, with the sample and the fill level, full/empty flags and the write and
// overflow counters after that command; cfg writes capacity_log2 and is always ready.
// A taken command's memory read and status are registered in the read stage, then
// pass to the output register that drives rsp.
// Throughput: one command per cycle while rsp is taken and no clearing sweep runs;
// the single-port-per-direction sample memory sets that figure.
// A stalled rsp holds the pending result and one more in the read stage; req drops
// ready when both are occupied, and during a clearing sweep.
// Reset: pointers and counters clear, capacity_log2 goes to 7, and a clearing sweep
// zeroes all MAX_DEPTH memory entries, one a cycle, with req not ready. A cfg
// transfer clears pointers and counters and sweeps entries 0 to capacity-1 the same
// way; entries above keep their contents unless a sweep still running spans them.
// Full buffer: a write drops the oldest sample and bumps the overflow counter.
`include "overwrite_ring_buffer_assert.svh"

module overwrite_ring_buffer #(
	parameter int MAX_DEPTH    = obr_pkg::DEF_MAX_DEPTH,
	parameter int SAMPLE_WIDTH = obr_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	obr_cfg_if.sink   cfg,
	obr_cmd_if.sink   req,
	obr_res_if.source rsp
);

	localparam int AW = $clog2(MAX_DEPTH);
	localparam int FW = $clog2(MAX_DEPTH + 1);

	obr_pkg::stat_t          stat_s1;
	logic [FW-1:0]           fill_s1;
	logic                    s1_adv;
	logic                    ram_we, ram_re;
	logic [AW-1:0]           ram_waddr, ram_raddr;
	logic [SAMPLE_WIDTH-1:0] ram_wdata, ram_rdata;
	logic                    out_valid_q;
	logic                    rd_stall;

	// read stage moves on when the output register is free or being drained
	assign s1_adv = !out_valid_q || rsp.ready;

	// a memory read waiting in the read stage
	assign rd_stall = stat_s1.valid && !stat_s1.zero && !s1_adv;

	obr_ctrl #(
		.MAX_DEPTH    (MAX_DEPTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.s1_adv    (s1_adv),
		.stat_s1   (stat_s1),
		.fill_s1   (fill_s1),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	obr_ram #(
		.WIDTH (SAMPLE_WIDTH),
		.DEPTH (MAX_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= stat_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && stat_s1.valid) begin
			// writes and empty reads/peeks report a zero sample
			rsp.sample_out      <= stat_s1.zero ? '0 : ram_rdata;
			rsp.fill_level      <= fill_s1;
			rsp.is_full         <= stat_s1.full;
			rsp.is_empty        <= stat_s1.empty;
			rsp.writes_total    <= stat_s1.writes;
			rsp.overflows_total <= stat_s1.overflows;
		end
	end

	assign rsp.valid = out_valid_q;

	`OBR_ASSERT_NEXT(a_rdata_held, rd_stall, $stable(ram_rdata), "read data moved in a stall")

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 400000;
	// hold-off of the result side long enough to back the block up to its input
	localparam int LONG_HOLD   = 300;

	typedef struct {
		obr_pkg::cmd_t      cmd;
		logic signed [15:0] sample;
		logic [6:0]        index;
	} ring_cmd_t;

	typedef struct {
		logic signed [15:0] sample;
		logic [7:0]         fill;
		logic               full;
		logic               empty;
		logic [31:0]        writes;
		logic [31:0]        drops;
	} ring_status_t;

	logic clk;
	logic arst_n;

	obr_cfg_if cfg_ch ();
	obr_cmd_if req_ch ();
	obr_res_if rsp_ch ();

	overwrite_ring_buffer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// commands waiting for the driver, and the status each accepted command should produce
	ring_cmd_t    pending_cmds[$];
	ring_status_t due_results[$];

	// shadow copy of the buffer
	logic signed [15:0] shadow_samples[128];
	logic [6:0]         shadow_head;
	logic [6:0]         shadow_tail;
	logic [7:0]         shadow_fill;
	logic [31:0]        shadow_writes;
	logic [31:0]        shadow_drops;
	logic [2:0]         shadow_log2;

	int  cmds_queued = 0;
	int  cmds_taken = 0;
	int  fail_count = 0;
	int  cfg_writes = 0;
	int  full_seen = 0;
	int  empty_seen = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  cycle_count = 0;
	logic idle_allowed = 1'b0;
	logic rsp_hold = 1'b0;

	always #5 clk = ~clk;

	// generous watchdog; also drives the on/off pattern of random idling
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				due_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= 30)
			$display("mismatch @%0t: %s", $time, what);
	endtask

	// pointers and counters back to zero, slots in use cleared, upper slots untouched
	function automatic void shadow_reinit(input logic [2:0] lg);
		int cap;
		cap = 1 << lg;
		shadow_log2   = lg;
		shadow_head   = '0;
		shadow_tail   = '0;
		shadow_fill   = '0;
		shadow_writes = '0;
		shadow_drops  = '0;
		for (int i = 0; i < cap; i++)
			shadow_samples[i] = '0;
	endfunction

	// one command against the shadow buffer; returns the status it should report
	function automatic ring_status_t apply_command(input obr_pkg::cmd_t c,
			input logic signed [15:0] s, input logic [6:0] idx);
		ring_status_t r;
		logic [7:0]   cap;
		logic [6:0]   mask;
		cap  = 8'd1 << shadow_log2;
		mask = 7'(cap - 8'd1);
		r    = '{default: '0};
		shadow_head &= mask;
		shadow_tail &= mask;
		case (c)
			obr_pkg::CMD_WRITE: begin
				shadow_samples[shadow_head] = s;
				shadow_head = 7'(shadow_head + 7'd1) & mask;
				// full: overwrite oldest, tail follows head
				if (shadow_fill >= cap) begin
					shadow_tail  = 7'(shadow_tail + 7'd1) & mask;
					shadow_drops = shadow_drops + 32'd1;
				end else begin
					shadow_fill = shadow_fill + 8'd1;
				end
				shadow_writes = shadow_writes + 32'd1;
			end
			obr_pkg::CMD_READ: begin
				if (shadow_fill != 0) begin
					r.sample    = shadow_samples[shadow_tail];
					shadow_tail = 7'(shadow_tail + 7'd1) & mask;
					shadow_fill = shadow_fill - 8'd1;
				end
			end
			obr_pkg::CMD_PEEK: begin
				if (shadow_fill != 0)
					r.sample = shadow_samples[7'(shadow_head - 7'd1) & mask];
			end
			default: begin
				// no bound check: may hit a cleared or stale slot
				r.sample = shadow_samples[7'(shadow_tail + idx) & mask];
			end
		endcase
		r.fill   = shadow_fill;
		r.full   = (shadow_fill == cap);
		r.empty  = (shadow_fill == 0);
		r.writes = shadow_writes;
		r.drops  = shadow_drops;
		return r;
	endfunction

	// command driver: presents queued commands, predicts each one at its transfer
	always @(posedge clk or negedge arst_n) begin : cmd_driver
		ring_cmd_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				due_results.push_back(apply_command(req_ch.cmd, req_ch.sample_in,
					req_ch.entry_index));
				cmds_taken++;
			end
			// a command on offer stays put until it is taken
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_cmds.size() == 0) begin
					req_ch.valid <= 1'b0;
				end else if (idle_allowed && !cycle_count[8] && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 10);
					req_ch.valid <= 1'b0;
				end else begin
					nxt = pending_cmds.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.cmd         <= nxt.cmd;
					req_ch.sample_in   <= nxt.sample;
					req_ch.entry_index <= nxt.index;
				end
			end
		end
	end

	// result monitor: field-by-field check against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : result_monitor
		ring_status_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_results.size() == 0) begin
					report_mismatch("result transfer with no command outstanding");
				end else begin
					want = due_results.pop_front();
					if (rsp_ch.sample_out !== want.sample)
						report_mismatch($sformatf("sample_out %0d, want %0d",
							rsp_ch.sample_out, want.sample));
					if (rsp_ch.fill_level !== want.fill)
						report_mismatch($sformatf("fill_level %0d, want %0d",
							rsp_ch.fill_level, want.fill));
					if (rsp_ch.is_full !== want.full)
						report_mismatch($sformatf("is_full %b, want %b",
							rsp_ch.is_full, want.full));
					if (rsp_ch.is_empty !== want.empty)
						report_mismatch($sformatf("is_empty %b, want %b",
							rsp_ch.is_empty, want.empty));
					if (rsp_ch.writes_total !== want.writes)
						report_mismatch($sformatf("writes_total %0d, want %0d",
							rsp_ch.writes_total, want.writes));
					if (rsp_ch.overflows_total !== want.drops)
						report_mismatch($sformatf("overflows_total %0d, want %0d",
							rsp_ch.overflows_total, want.drops));
					if (want.full)
						full_seen++;
					if (want.empty)
						empty_seen++;
				end
			end
			if (rsp_hold) begin
				rsp_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_allowed && cycle_count[9:8] != 2'b11 &&
					$urandom_range(0, 9) == 0) begin
				recv_gap = $urandom_range(0, 10);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// one long receiver hold-off: the block's two result slots fill and req backs up
	initial begin
		wait (cmds_taken >= 450);
		@(posedge clk);
		rsp_hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	task automatic push_cmd(input obr_pkg::cmd_t c, input logic [15:0] s,
			input logic [6:0] idx);
		ring_cmd_t item;
		item.cmd    = c;
		item.sample = s;
		item.index  = idx;
		pending_cmds.push_back(item);
		cmds_queued++;
	endtask

	// random commands in runs of 32 with a varying mix: write-heavy runs fill the
	// buffer into overwrite, read-heavy runs drain it to empty
	task automatic queue_random(input int n);
		int mix;
		int roll;
		int wr_pct;
		int rd_pct;
		int pk_pct;
		mix    = 0;
		wr_pct = 25;
		rd_pct = 50;
		pk_pct = 75;
		for (int i = 0; i < n; i++) begin
			if (i % 32 == 0) begin
				mix = $urandom_range(0, 3);
				case (mix)
					0, 1: begin
						wr_pct = 70; rd_pct = 80; pk_pct = 90;
					end
					2: begin
						wr_pct = 25; rd_pct = 75; pk_pct = 87;
					end
					default: begin
						wr_pct = 25; rd_pct = 50; pk_pct = 75;
					end
				endcase
			end
			roll = $urandom_range(0, 99);
			if (roll < wr_pct)
				push_cmd(obr_pkg::CMD_WRITE, 16'($urandom), 7'($urandom));
			else if (roll < rd_pct)
				push_cmd(obr_pkg::CMD_READ, 16'($urandom), 7'($urandom));
			else if (roll < pk_pct)
				push_cmd(obr_pkg::CMD_PEEK, 16'($urandom), 7'($urandom));
			else
				push_cmd(obr_pkg::CMD_GET, 16'($urandom), 7'($urandom_range(0, 127)));
		end
	endtask

	// sender holds back until every issued command has had its result
	task automatic wait_drained();
		do
			@(posedge clk);
		while (cmds_taken != cmds_queued || due_results.size() != 0);
	endtask

	task automatic write_capacity(input logic [obr_pkg::CAP_LOG2_W-1:0] lg);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= lg;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		shadow_reinit(lg);
		cfg_writes++;
	endtask

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.data        = '0;
		req_ch.valid       = 1'b0;
		req_ch.cmd         = obr_pkg::CMD_WRITE;
		req_ch.sample_in   = '0;
		req_ch.entry_index = '0;
		rsp_ch.ready       = 1'b0;
		for (int i = 0; i < 128; i++)
			shadow_samples[i] = '0;
		shadow_reinit(obr_pkg::CAP_LOG2_RST);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		idle_allowed <= 1'b1;

		// reset capacity (128 slots): empty-buffer corner cases, sample extremes,
		// get past the fill level, and a get that lands on a stale slot
		push_cmd(obr_pkg::CMD_READ, 16'h0000, 7'd0);
		push_cmd(obr_pkg::CMD_PEEK, 16'h0000, 7'd0);
		push_cmd(obr_pkg::CMD_GET, 16'h0000, 7'd127);
		push_cmd(obr_pkg::CMD_WRITE, 16'h7FFF, 7'd0);
		push_cmd(obr_pkg::CMD_WRITE, 16'h8000, 7'd0);
		push_cmd(obr_pkg::CMD_WRITE, 16'hFFFF, 7'd0);
		push_cmd(obr_pkg::CMD_WRITE, 16'h0000, 7'd0);
		push_cmd(obr_pkg::CMD_PEEK, 16'h0000, 7'd0);
		push_cmd(obr_pkg::CMD_GET, 16'h0000, 7'd0);
		push_cmd(obr_pkg::CMD_GET, 16'h0000, 7'd3);
		push_cmd(obr_pkg::CMD_GET, 16'h0000, 7'd100);
		push_cmd(obr_pkg::CMD_READ, 16'h0000, 7'd0);
		push_cmd(obr_pkg::CMD_READ, 16'h0000, 7'd0);
		push_cmd(obr_pkg::CMD_GET, 16'hFFFF, 7'd127);
		push_cmd(obr_pkg::CMD_READ, 16'h0000, 7'd0);
		push_cmd(obr_pkg::CMD_READ, 16'h0000, 7'd0);
		push_cmd(obr_pkg::CMD_READ, 16'h0000, 7'd0);
		push_cmd(obr_pkg::CMD_PEEK, 16'h0000, 7'd0);
		queue_random(300);
		wait_drained();

		// walk the capacity from one slot upwards
		for (int lg = 0; lg < 7; lg++) begin
			write_capacity(3'(lg));
			if (lg == 0) begin
				// single slot: every write after the first overwrites slot 0
				push_cmd(obr_pkg::CMD_WRITE, 16'h1234, 7'd0);
				push_cmd(obr_pkg::CMD_WRITE, 16'h5555, 7'd0);
				push_cmd(obr_pkg::CMD_PEEK, 16'h0000, 7'd0);
				push_cmd(obr_pkg::CMD_GET, 16'h0000, 7'd127);
				push_cmd(obr_pkg::CMD_READ, 16'h0000, 7'd0);
				push_cmd(obr_pkg::CMD_READ, 16'h0000, 7'd0);
				push_cmd(obr_pkg::CMD_GET, 16'h0000, 7'd0);
			end
			queue_random(140);
			wait_drained();
		end

		// back to full depth, both sides flat out to the end
		idle_allowed <= 1'b0;
		write_capacity(3'd7);
		queue_random(300);
		wait_drained();

		// let any stray result show up
		repeat (20) @(posedge clk);

		$display("%0d commands checked across %0d capacity writes (1 to 128 slots)",
			cmds_taken, cfg_writes);
		$display("%0d results with the buffer full, %0d with it empty", full_seen, empty_seen);
		if (fail_count == 0 && due_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results missing", fail_count, due_results.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
